/* hdl/bai_pkg.sv */
// Shared types and constants for the bounded array insert/erase block.
// Used by bai_ctrl, bai_dpath and the top level; depends on nothing.
package bai_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = 7;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_ERASE  = 3'd3,
        REQ_READ   = 3'd4,
        REQ_WRITE  = 3'd5,
        REQ_RESIZE = 3'd6,
        REQ_CLEAR  = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUSH,
        DP_POP,
        DP_RD_IDX,
        DP_WR_IDX,
        DP_INS_RD,
        DP_INS_WR,
        DP_INS_LAST,
        DP_ERS_RD,
        DP_ERS_WR,
        DP_ERS_LAST,
        DP_FILL,
        DP_FILL_LAST,
        DP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic ok;
        logic ins_done;
        logic ers_done;
        logic fill_done;
        logic out_free;
    } t_stat;

endpackage

/* hdl/bai_dpath.sv */
// Datapath: entry memory, live length, request registers, shift pointer and
// the output register. Driven by bai_ctrl commands; uses bai_pkg.
module bai_dpath import bai_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  t_req                i_req,
    input  logic [CNT_W-1:0]    i_index,
    input  logic [DATA_W-1:0]   i_value,
    input  logic [CNT_W-1:0]    i_new_length,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [DATA_W-1:0]   o_read_value,
    output logic [CNT_W-1:0]    o_length,
    output t_status             o_status
);

    localparam logic [CNT_W-1:0] MaxLen = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_nlen;
    logic [DATA_W-1:0] r_val;
    t_req              r_req;
    t_status           r_status;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rd;
    logic [CNT_W-1:0]  r_out_len;
    t_status           r_out_st;

    t_status           n_status;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [CNT_W-1:0]  ptr_dec;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W:0]    ptr_next_wide;

    assign ptr_dec       = r_ptr - CNT_W'(1);
    assign ptr_inc       = r_ptr + CNT_W'(1);
    assign ptr_next_wide = {1'b0, r_ptr} + (CNT_W+1)'(1);

    // Request check against the current length; failed requests change nothing.
    always_comb begin
        n_status = ST_OK;
        unique case (i_req)
            REQ_PUSH:   if (r_len >= MaxLen) n_status = ST_FULL;
            REQ_POP:    if (r_len == '0) n_status = ST_EMPTY;
            REQ_INSERT: begin
                if (i_index > r_len) begin
                    n_status = ST_RANGE;
                end else if (r_len >= MaxLen) begin
                    n_status = ST_FULL;
                end
            end
            REQ_ERASE, REQ_READ, REQ_WRITE: begin
                if (i_index >= r_len) n_status = ST_RANGE;
            end
            REQ_RESIZE: if (i_new_length > MaxLen) n_status = ST_FULL;
            REQ_CLEAR:  n_status = ST_OK;
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_ptr[ADDR_W-1:0];
        wr_data = r_val;
        unique case (i_cmd.op)
            DP_RD_IDX: rd_en = 1'b1;
            DP_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_dec[ADDR_W-1:0];
            end
            DP_ERS_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_inc[ADDR_W-1:0];
            end
            DP_PUSH: begin
                wr_en   = 1'b1;
                wr_addr = r_len[ADDR_W-1:0];
            end
            DP_WR_IDX, DP_INS_LAST: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[ADDR_W-1:0];
            end
            DP_INS_WR, DP_ERS_WR: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
            end
            DP_FILL: wr_en = 1'b1;
            default: begin
                rd_en = 1'b0;
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_req    <= i_req;
                    r_idx    <= i_index;
                    r_val    <= i_value;
                    r_nlen   <= i_new_length;
                    r_status <= n_status;
                    r_ptr    <= (i_req == REQ_ERASE) ? i_index : r_len;
                end
                DP_PUSH, DP_INS_LAST:    r_len <= r_len + CNT_W'(1);
                DP_POP, DP_ERS_LAST:     r_len <= r_len - CNT_W'(1);
                DP_INS_WR:               r_ptr <= ptr_dec;
                DP_ERS_WR, DP_FILL:      r_ptr <= ptr_inc;
                DP_FILL_LAST:            r_len <= r_nlen;
                DP_CLEAR:                r_len <= '0;
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_rd    <= (r_req == REQ_READ && r_status == ST_OK) ? r_rdata : '0;
                r_out_len   <= r_len;
                r_out_st    <= r_status;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req       = r_req;
    assign o_stat.ok        = (r_status == ST_OK);
    assign o_stat.ins_done  = (r_ptr == r_idx);
    assign o_stat.ers_done  = (ptr_next_wide >= {1'b0, r_len});
    assign o_stat.fill_done = (r_ptr >= r_nlen);
    assign o_stat.out_free  = !r_out_valid || i_tready;

    assign o_tvalid     = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_length     = r_out_len;
    assign o_status     = r_out_st;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MaxLen)
        else $error("live length exceeds the array depth");

    a_fail_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != DP_LOAD && r_status != ST_OK) |-> i_cmd.op == DP_NOP)
        else $error("a failed request issued a datapath operation");

    a_ins_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_INS_WR) |-> (r_ptr > r_idx && r_ptr <= r_len))
        else $error("insert shift pointer left its window");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_tready))
        else $error("result register overwritten while still held");

endmodule

/* hdl/bai_ctrl.sv */
// Controller state machine: sequences each request as datapath commands.
// Depends on bai_pkg; drives bai_dpath.
module bai_ctrl import bai_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_ERS_RD,
        S_ERS_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = DP_NOP;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.ok) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                    unique case (i_stat.req)
                        REQ_PUSH:  o_cmd.op = DP_PUSH;
                        REQ_POP:   o_cmd.op = DP_POP;
                        REQ_INSERT: begin
                            if (i_stat.ins_done) begin
                                o_cmd.op = DP_INS_LAST;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        REQ_ERASE: begin
                            if (i_stat.ers_done) begin
                                o_cmd.op = DP_ERS_LAST;
                            end else begin
                                n_state = S_ERS_RD;
                            end
                        end
                        REQ_READ:  o_cmd.op = DP_RD_IDX;
                        REQ_WRITE: o_cmd.op = DP_WR_IDX;
                        REQ_RESIZE: begin
                            // Fill one new entry per cycle until the target length.
                            if (i_stat.fill_done) begin
                                o_cmd.op = DP_FILL_LAST;
                            end else begin
                                o_cmd.op = DP_FILL;
                                n_state  = S_DECODE;
                            end
                        end
                        REQ_CLEAR: o_cmd.op = DP_CLEAR;
                    endcase
                end
            end
            S_INS_RD: begin
                o_cmd.op = DP_INS_RD;
                n_state  = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd.op = DP_INS_WR;
                n_state  = S_DECODE;
            end
            S_ERS_RD: begin
                o_cmd.op = DP_ERS_RD;
                n_state  = S_ERS_WR;
            end
            S_ERS_WR: begin
                o_cmd.op = DP_ERS_WR;
                n_state  = S_DECODE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* hdl/bounded_array_insert_erase.sv */
// Top level of the bounded array: a 64-entry array of signed words with a
// live length, serving push, pop, insert, erase, read, write, resize, clear.
//
// Channels: requests enter on the s_axis group, the opcode in tuser and the
// index, value and target length in tdata. Each request gives exactly one
// result transfer on the m_axis group: the word read, the new length and a
// status (ok, index out of range, empty, full).
// Sequence: a request is registered on acceptance, checked in the decode
// state, and its result goes into the output register. Insert and erase
// shift one entry per pass: each shift reads one word, writes it one place
// over and then goes back through the decode state for the next pointer
// check. Resize writes the new entries up to the target in the decode
// state. A new request is accepted in the cycle after the result is loaded,
// so no new request is taken until the last one is through.
// The result sits in an output register: a request can be accepted while
// that result waits, and a stalled receiver only holds the block once the
// next result is finished.
// Reset (synchronous, active low) empties the array and drops any pending
// result; entry contents are not cleared and need no clearing pass.
module bounded_array_insert_erase import bai_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // index[6:0], value[38:7], new_length[45:39]
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_value[31:0], length[38:32], status[40:39]
);

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  length;
    t_status           status;

    bai_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bai_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req        (t_req'(s_axis_tuser)),
        .i_index      (s_axis_tdata[6:0]),
        .i_value      (s_axis_tdata[38:7]),
        .i_new_length (s_axis_tdata[45:39]),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_read_value (read_value),
        .o_length     (length),
        .o_status     (status)
    );

    assign m_axis_tdata = {7'd0, status, length, read_value};

endmodule

/* bench/tb_bounded_array_insert_erase.sv */
// Self-checking testbench for bounded_array_insert_erase: a request stream drives the
// s_axis side and every m_axis transfer is checked against a shadow copy of the array.
// Depends on bai_pkg and the top level only.
module tb_bounded_array_insert_erase;
    timeunit 1ns;
    timeprecision 1ps;

    import bai_pkg::*;

    localparam int N_RANDOM   = 1600;
    localparam int LONG_HOLD  = 300;
    localparam int TAIL_WAIT  = 200;

    typedef struct packed {
        logic [31:0] rd;
        logic [6:0]  len;
        t_status     st;
    } t_reply;

    typedef struct {
        t_req        req;
        logic [6:0]  idx;
        logic [31:0] word;
        logic [6:0]  nlen;
        int          gap;    // idle cycles before this request is offered
        bit          drain;  // hold the sender until every reply is back
        t_reply      want;
    } t_array_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // index[6:0], value[38:7], new_length[45:39]
    logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // read_value[31:0], length[38:32], status[40:39]

    bounded_array_insert_erase dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow of the array, advanced in request order while the stimulus is built.
    logic [31:0] shadow_words [DEPTH];
    int          shadow_len = 0;

    t_array_req  pending_reqs [$];
    t_reply      awaited_replies [$];
    t_array_req  on_bus;
    int          idle_run = 0;
    int          replies_seen = 0;
    int          err_count = 0;
    int          sink_wait = 0;
    bit          long_hold_done = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAIL bounded_array_insert_erase");
        $finish;
    end

    function automatic t_reply apply_array_req(t_req req, logic [6:0] idx, logic [31:0] word,
                                               logic [6:0] nlen);
        t_reply res;
        int     i;
        res.rd = '0;
        res.st = ST_OK;
        case (req)
            REQ_PUSH: begin
                if (shadow_len >= DEPTH) begin
                    res.st = ST_FULL;
                end else begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
            end
            REQ_POP: begin
                if (shadow_len == 0) res.st = ST_EMPTY;
                else shadow_len--;
            end
            REQ_INSERT: begin
                if (int'(idx) > shadow_len) begin
                    res.st = ST_RANGE;
                end else if (shadow_len >= DEPTH) begin
                    res.st = ST_FULL;
                end else begin
                    for (i = shadow_len; i > int'(idx); i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[idx] = word;
                    shadow_len++;
                end
            end
            REQ_ERASE: begin
                if (int'(idx) >= shadow_len) begin
                    res.st = ST_RANGE;
                end else begin
                    for (i = int'(idx); i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            REQ_READ: begin
                if (int'(idx) >= shadow_len) res.st = ST_RANGE;
                else res.rd = shadow_words[idx];
            end
            REQ_WRITE: begin
                if (int'(idx) >= shadow_len) res.st = ST_RANGE;
                else shadow_words[idx] = word;
            end
            REQ_RESIZE: begin
                if (int'(nlen) > DEPTH) begin
                    res.st = ST_FULL;
                end else begin
                    for (i = shadow_len; i < int'(nlen); i++)
                        shadow_words[i] = word;
                    shadow_len = int'(nlen);
                end
            end
            default: shadow_len = 0;
        endcase
        res.len = shadow_len[6:0];
        return res;
    endfunction

    task automatic add_req(t_req req, int idx, logic [31:0] word, int nlen, int gap);
        t_array_req it;
        it.req   = req;
        it.idx   = idx[6:0];
        it.word  = word;
        it.nlen  = nlen[6:0];
        it.gap   = gap;
        it.drain = 1'b0;
        it.want  = apply_array_req(it.req, it.idx, it.word, it.nlen);
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    task automatic add_drain();
        t_array_req it;
        it.req   = REQ_CLEAR;
        it.idx   = '0;
        it.word  = '0;
        it.nlen  = '0;
        it.gap   = 0;
        it.drain = 1'b1;
        it.want  = '0;
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    // Mostly short idle runs, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Phase 0 grows the array toward full, phase 1 shrinks it, phase 2 mixes evenly.
    function automatic t_req pick_req(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (phase == 0) begin
            if (r < 35) return REQ_PUSH;
            if (r < 65) return REQ_INSERT;
            if (r < 75) return REQ_READ;
            if (r < 85) return REQ_WRITE;
            if (r < 90) return REQ_ERASE;
            if (r < 95) return REQ_POP;
            if (r < 98) return REQ_RESIZE;
            return REQ_CLEAR;
        end else if (phase == 1) begin
            if (r < 30) return REQ_POP;
            if (r < 65) return REQ_ERASE;
            if (r < 77) return REQ_READ;
            if (r < 87) return REQ_WRITE;
            if (r < 92) return REQ_PUSH;
            if (r < 97) return REQ_INSERT;
            if (r < 99) return REQ_RESIZE;
            return REQ_CLEAR;
        end
        return t_req'($urandom_range(0, 7));
    endfunction

    function automatic int pick_index(t_req req);
        int r;
        int top;
        r = $urandom_range(0, 99);
        // Insert may go one past the last live entry; the others may not.
        top = (req == REQ_INSERT) ? shadow_len : shadow_len - 1;
        if (r < 70) return (top < 0) ? 0 : $urandom_range(0, top);
        if (r < 80) return shadow_len;
        if (r < 85) return 0;
        if (r < 95) return $urandom_range(0, 64);
        return $urandom_range(65, 127);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 64);
        if (r < 60) return (shadow_len > 61) ? shadow_len : shadow_len + $urandom_range(0, 3);
        if (r < 75) return 64;
        if (r < 85) return 0;
        return $urandom_range(65, 127);
    endfunction

    initial begin
        t_req req;
        int   n;
        int   gap;

        // Directed part, starting from the empty array.
        add_req(REQ_POP,    0,  32'h1, 0, 0);          // pop while empty
        add_req(REQ_ERASE,  0,  32'h0, 0, 1);          // erase on empty array
        add_req(REQ_READ,   0,  32'h0, 0, 0);
        add_req(REQ_WRITE,  0,  32'h5, 0, 0);
        add_req(REQ_INSERT, 1,  32'h7, 0, 2);          // insert beyond length
        add_req(REQ_INSERT, 0,  32'h8000_0000, 0, 0);  // insert into empty array
        add_req(REQ_PUSH,   0,  32'h7FFF_FFFF, 0, 0);
        add_req(REQ_PUSH,   0,  32'h0, 0, 0);
        add_req(REQ_INSERT, 3,  32'hFFFF_FFFF, 0, 0);  // index equal to length appends
        add_req(REQ_INSERT, 1,  32'h1234_5678, 0, 3);  // shift the tail up
        add_req(REQ_READ,   1,  32'h0, 0, 0);
        add_req(REQ_ERASE,  0,  32'h0, 0, 0);          // shift everything down
        add_req(REQ_ERASE,  3,  32'h0, 0, 0);          // erase the last entry
        add_req(REQ_WRITE,  2,  32'hDEAD_BEEF, 0, 0);
        add_req(REQ_READ,   2,  32'h0, 0, 1);
        add_req(REQ_RESIZE, 0,  32'h5A5A_5A5A, 64, 0); // grow to full with fill
        add_req(REQ_PUSH,   0,  32'h3, 0, 0);          // push when full
        add_req(REQ_INSERT, 64, 32'h4, 0, 0);          // valid index but full
        add_req(REQ_INSERT, 65, 32'h4, 0, 0);          // index check wins over full
        add_req(REQ_READ,   64, 32'h0, 0, 0);
        add_req(REQ_READ,   63, 32'h0, 0, 0);
        add_req(REQ_RESIZE, 0,  32'h6, 127, 0);        // resize beyond the depth
        add_req(REQ_RESIZE, 0,  32'h6, 5, 0);          // shrink only lowers the length
        add_req(REQ_RESIZE, 0,  32'hFFFF_FFFF, 9, 0);
        add_req(REQ_CLEAR,  0,  32'h0, 0, 0);
        add_drain();

        for (n = 0; n < N_RANDOM; n++) begin
            req = pick_req((n / 120) % 3);
            gap = ((n / 150) % 4 == 1) ? 0 : pick_gap();
            add_req(req, pick_index(req), pick_word(), pick_length(), gap);
            if (n % 400 == 399) add_drain();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (err_count == 0) begin
            $display("PASS bounded_array_insert_erase");
        end else begin
            $display("FAIL bounded_array_insert_erase");
        end
        $finish;
    end

    // Request driver: offers the queued requests, honoring each one's idle gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= REQ_PUSH;
            idle_run = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                awaited_replies.insert(awaited_replies.size(), on_bus.want);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs[0].drain) begin
                    if (awaited_replies.size() == 0) pending_reqs.delete(0);
                    s_axis_tvalid <= 1'b0;
                end else if (idle_run < pending_reqs[0].gap) begin
                    idle_run++;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    on_bus = pending_reqs.pop_front();
                    idle_run = 0;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, on_bus.nlen, on_bus.word, on_bus.idx};
                    s_axis_tuser  <= on_bus.req;
                end
            end
        end
    end

    // Receiver ready: random stalls, a quiet window every few hundred replies,
    // and one long hold-off so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end else if (!long_hold_done && replies_seen >= 400) begin
            long_hold_done = 1'b1;
            sink_wait = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ((replies_seen / 150) % 4 != 2) sink_wait = pick_gap();
        end
    end

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Reply checker: each transfer is matched against the oldest awaited reply.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rd  = m_axis_tdata[31:0];
            got.len = m_axis_tdata[38:32];
            got.st  = t_status'(m_axis_tdata[40:39]);
            if (awaited_replies.size() == 0) begin
                flag_error($sformatf("reply %0d arrived with none awaited", replies_seen));
            end else begin
                want = awaited_replies.pop_front();
                if (got.rd !== want.rd)
                    flag_error($sformatf("reply %0d read_value expected %0d got %0d",
                        replies_seen, $signed(want.rd), $signed(got.rd)));
                if (got.len !== want.len)
                    flag_error($sformatf("reply %0d length expected %0d got %0d",
                        replies_seen, want.len, got.len));
                if (got.st !== want.st)
                    flag_error($sformatf("reply %0d status expected %s got %0d",
                        replies_seen, want.st.name(), m_axis_tdata[40:39]));
            end
            replies_seen++;
        end
    end

endmodule
